// ===== hw/rtl/gn2_pkg.sv =====
`timescale 1ns / 1ps

package gn2_pkg;

    // Fixed formats of the noise datapath.
    localparam int TABLE_BITS     = 8;
    localparam int FRAC_BITS      = 16;
    localparam int POS_BITS       = 24;
    localparam int OUT_BITS       = 19;
    localparam int VAL_BITS       = 21;
    localparam int FADE_BITS      = 20;
    localparam int MID_DEPTH_BITS = 2;
    localparam int OUT_DEPTH_BITS = 4;

    // Request kinds.
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_EVAL = 1'b1;

    // Low two hash bits pick one of four diagonal gradients.
    localparam logic [TABLE_BITS-1:0] GRAD_SEL = 8'd3;

    // One request after the front end has taken it apart.
    typedef struct packed {
        logic                  is_eval;
        logic [TABLE_BITS-1:0] entry_index;
        logic [TABLE_BITS-1:0] entry_value;
        logic [TABLE_BITS-1:0] cell_x;
        logic [TABLE_BITS-1:0] cell_y;
        logic [FRAC_BITS-1:0]  frac_x;
        logic [FRAC_BITS-1:0]  frac_y;
    } gn2_item_t;

    // Dot product of a corner offset with its diagonal gradient.
    function automatic logic signed [VAL_BITS-1:0] gradient(
        input logic [TABLE_BITS-1:0]      h,
        input logic signed [VAL_BITS-1:0] dx,
        input logic signed [VAL_BITS-1:0] dy
    );
        logic [TABLE_BITS-1:0]      sel;
        logic signed [VAL_BITS-1:0] a;
        logic signed [VAL_BITS-1:0] b;
        sel = h & GRAD_SEL;
        a = sel[0] ? dx : -dx;
        b = sel[1] ? dy : -dy;
        return a + b;
    endfunction

endpackage

// ===== hw/rtl/gn2_fifo.sv =====
`timescale 1ns / 1ps

module gn2_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_BITS = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0]      entry_reg [DEPTH];
    logic [DEPTH_BITS-1:0] wr_ptr_reg;
    logic [DEPTH_BITS-1:0] rd_ptr_reg;
    logic [DEPTH_BITS:0]   count_reg;
    logic [DEPTH_BITS:0]   count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (DEPTH_BITS+1)'(DEPTH));
    assign rd_data = entry_reg[rd_ptr_reg];

    // Occupancy follows the writes and reads of this cycle.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/gn2_front.sv =====
`timescale 1ns / 1ps

module gn2_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           action,
    input  logic [7:0]                     entry_index,
    input  logic [7:0]                     entry_value,
    input  logic [gn2_pkg::POS_BITS-1:0]   x_position,
    input  logic [gn2_pkg::POS_BITS-1:0]   y_position,
    output logic                           item_valid,
    output gn2_pkg::gn2_item_t             item,
    input  logic                           item_ready
);

    logic               valid_reg;
    gn2_pkg::gn2_item_t item_reg;
    gn2_pkg::gn2_item_t item_next;
    logic               take;

    assign full       = valid_reg && !item_ready;
    assign take       = push && !full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Split each request into kind, cell corner and fractions.
    always_comb
    begin
        item_next.is_eval     = (action == gn2_pkg::ACTION_EVAL);
        item_next.entry_index = entry_index;
        item_next.entry_value = entry_value;
        item_next.cell_x      = x_position[gn2_pkg::FRAC_BITS +: gn2_pkg::TABLE_BITS];
        item_next.cell_y      = y_position[gn2_pkg::FRAC_BITS +: gn2_pkg::TABLE_BITS];
        item_next.frac_x      = x_position[gn2_pkg::FRAC_BITS-1:0];
        item_next.frac_y      = y_position[gn2_pkg::FRAC_BITS-1:0];
    end

    // Holding register in front of the request queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/gn2_back.sv =====
`timescale 1ns / 1ps

module gn2_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  gn2_pkg::gn2_item_t                  in_item,
    output logic                                out_valid,
    output logic [gn2_pkg::OUT_BITS-1:0]        out_noise
);

    localparam int TB = gn2_pkg::TABLE_BITS;
    localparam int FB = gn2_pkg::FRAC_BITS;
    localparam int VB = gn2_pkg::VAL_BITS;
    localparam int QB = gn2_pkg::FADE_BITS;
    localparam int ENTRIES = 1 << TB;

    // Three copies of the permutation table: one for the row lookups,
    // two for the four corner lookups.
    logic [TB-1:0] table_a [ENTRIES];
    logic [TB-1:0] table_b [ENTRIES];
    logic [TB-1:0] table_c [ENTRIES];

    // Stage A: request from the queue.
    logic               a_valid_reg;
    gn2_pkg::gn2_item_t a_item_reg;
    logic [2*FB-1:0]    a_sqx;
    logic [2*FB-1:0]    a_sqy;
    logic [TB-1:0]      a_cy1;

    // Stage B.
    logic            b_valid_reg;
    logic            b_eval_reg;
    logic [TB-1:0]   b_idx_reg;
    logic [TB-1:0]   b_val_reg;
    logic [TB-1:0]   b_cx_reg;
    logic [FB-1:0]   b_fx_reg;
    logic [FB-1:0]   b_fy_reg;
    logic [2*FB-1:0] b_sqx_reg;
    logic [2*FB-1:0] b_sqy_reg;
    logic [TB-1:0]   b_row0_reg;
    logic [TB-1:0]   b_row1_reg;
    logic [TB-1:0]   b_cx1;
    logic [TB-1:0]   b_addr00;
    logic [TB-1:0]   b_addr10;
    logic [TB-1:0]   b_addr01;
    logic [TB-1:0]   b_addr11;
    logic [2*FB+7:0] b_polyx;
    logic [2*FB+7:0] b_polyy;

    // Stage C.
    logic          c_valid_reg;
    logic [FB-1:0] c_fx_reg;
    logic [FB-1:0] c_fy_reg;
    logic [QB-1:0] c_q1x_reg;
    logic [QB-1:0] c_q1y_reg;
    logic [TB-1:0] c_h00_reg;
    logic [TB-1:0] c_h10_reg;
    logic [TB-1:0] c_h01_reg;
    logic [TB-1:0] c_h11_reg;
    logic signed [VB-1:0] c_dx0;
    logic signed [VB-1:0] c_dx1;
    logic signed [VB-1:0] c_dy0;
    logic signed [VB-1:0] c_dy1;
    logic [QB+FB-1:0] c_mx;
    logic [QB+FB-1:0] c_my;

    // Stage D and E: rest of the fade chain, gradients ride along.
    logic          d_valid_reg;
    logic [FB-1:0] d_fx_reg;
    logic [FB-1:0] d_fy_reg;
    logic [QB-1:0] d_q2x_reg;
    logic [QB-1:0] d_q2y_reg;
    logic signed [VB-1:0] d_g00_reg;
    logic signed [VB-1:0] d_g10_reg;
    logic signed [VB-1:0] d_g01_reg;
    logic signed [VB-1:0] d_g11_reg;
    logic [QB+FB-1:0] d_mx;
    logic [QB+FB-1:0] d_my;

    logic          e_valid_reg;
    logic [FB-1:0] e_fx_reg;
    logic [FB-1:0] e_fy_reg;
    logic [QB-1:0] e_q3x_reg;
    logic [QB-1:0] e_q3y_reg;
    logic signed [VB-1:0] e_g00_reg;
    logic signed [VB-1:0] e_g10_reg;
    logic signed [VB-1:0] e_g01_reg;
    logic signed [VB-1:0] e_g11_reg;
    logic [QB+FB-1:0] e_mx;
    logic [QB+FB-1:0] e_my;

    // Stage F: fade weights ready, first blend products.
    logic          f_valid_reg;
    logic [QB-1:0] f_u_reg;
    logic [QB-1:0] f_v_reg;
    logic signed [VB-1:0] f_g00_reg;
    logic signed [VB-1:0] f_g10_reg;
    logic signed [VB-1:0] f_g01_reg;
    logic signed [VB-1:0] f_g11_reg;
    logic signed [2*VB-1:0] f_prod0;
    logic signed [2*VB-1:0] f_prod1;

    // Stage G, H and I: finish the two blends along x, then blend along y.
    logic                   g_valid_reg;
    logic [QB-1:0]          g_v_reg;
    logic signed [VB-1:0]   g_g00_reg;
    logic signed [VB-1:0]   g_g01_reg;
    logic signed [2*VB-1:0] g_prod0_reg;
    logic signed [2*VB-1:0] g_prod1_reg;

    logic                   h_valid_reg;
    logic [QB-1:0]          h_v_reg;
    logic signed [VB-1:0]   h_l0_reg;
    logic signed [VB-1:0]   h_l1_reg;
    logic signed [2*VB-1:0] h_prod;

    logic                   i_valid_reg;
    logic signed [VB-1:0]   i_l0_reg;
    logic signed [2*VB-1:0] i_prod_reg;
    logic signed [VB-1:0]   i_noise;

    // Stage A: squares of the fractions, next row index.
    assign a_sqx = a_item_reg.frac_x * a_item_reg.frac_x;
    assign a_sqy = a_item_reg.frac_y * a_item_reg.frac_y;
    assign a_cy1 = a_item_reg.cell_y + 1'b1;

    // Stage B: corner addresses wrap modulo the table size, and the
    // first fade term 6t^2 - 15tS + 10S^2, scaled down by S.
    assign b_cx1    = b_cx_reg + 1'b1;
    assign b_addr00 = b_cx_reg + b_row0_reg;
    assign b_addr10 = b_cx1 + b_row0_reg;
    assign b_addr01 = b_cx_reg + b_row1_reg;
    assign b_addr11 = b_cx1 + b_row1_reg;
    assign b_polyx = ({8'd0, b_sqx_reg} * 40'd6) + (40'd10 << (2 * FB))
                   - (({24'd0, b_fx_reg} * 40'd15) << FB);
    assign b_polyy = ({8'd0, b_sqy_reg} * 40'd6) + (40'd10 << (2 * FB))
                   - (({24'd0, b_fy_reg} * 40'd15) << FB);

    // Stage C: corner offsets are the fraction, or the fraction less one.
    assign c_dx0 = $signed({{(VB-FB){1'b0}}, c_fx_reg});
    assign c_dx1 = $signed({{(VB-FB){1'b1}}, c_fx_reg});
    assign c_dy0 = $signed({{(VB-FB){1'b0}}, c_fy_reg});
    assign c_dy1 = $signed({{(VB-FB){1'b1}}, c_fy_reg});
    assign c_mx  = c_q1x_reg * c_fx_reg;
    assign c_my  = c_q1y_reg * c_fy_reg;
    assign d_mx  = d_q2x_reg * d_fx_reg;
    assign d_my  = d_q2y_reg * d_fy_reg;
    assign e_mx  = e_q3x_reg * e_fx_reg;
    assign e_my  = e_q3y_reg * e_fy_reg;

    // Blends: a + floor((b - a) * w / S).
    assign f_prod0 = (f_g10_reg - f_g00_reg) * $signed({1'b0, f_u_reg});
    assign f_prod1 = (f_g11_reg - f_g01_reg) * $signed({1'b0, f_u_reg});
    assign h_prod  = (h_l1_reg - h_l0_reg) * $signed({1'b0, h_v_reg});
    assign i_noise = i_l0_reg + i_prod_reg[FB+VB-1:FB];

    assign out_valid = i_valid_reg;
    assign out_noise = i_noise[gn2_pkg::OUT_BITS-1:0];

    // Table copies: a load writes each copy at the stage where evaluations
    // read it, so every request sees exactly the loads ahead of it.
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && !a_item_reg.is_eval)
        begin
            table_a[a_item_reg.entry_index] <= a_item_reg.entry_value;
        end
        b_row0_reg <= table_a[a_item_reg.cell_y];
        b_row1_reg <= table_a[a_cy1];
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && !b_eval_reg)
        begin
            table_b[b_idx_reg] <= b_val_reg;
        end
        c_h00_reg <= table_b[b_addr00];
        c_h10_reg <= table_b[b_addr10];
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && !b_eval_reg)
        begin
            table_c[b_idx_reg] <= b_val_reg;
        end
        c_h01_reg <= table_c[b_addr01];
        c_h11_reg <= table_c[b_addr11];
    end

    // Stage valid bits; loads leave the pipeline after the table writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && b_eval_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_item_reg <= in_item;

        b_eval_reg <= a_item_reg.is_eval;
        b_idx_reg  <= a_item_reg.entry_index;
        b_val_reg  <= a_item_reg.entry_value;
        b_cx_reg   <= a_item_reg.cell_x;
        b_fx_reg   <= a_item_reg.frac_x;
        b_fy_reg   <= a_item_reg.frac_y;
        b_sqx_reg  <= a_sqx;
        b_sqy_reg  <= a_sqy;

        c_fx_reg  <= b_fx_reg;
        c_fy_reg  <= b_fy_reg;
        c_q1x_reg <= b_polyx[FB+QB-1:FB];
        c_q1y_reg <= b_polyy[FB+QB-1:FB];

        d_fx_reg  <= c_fx_reg;
        d_fy_reg  <= c_fy_reg;
        d_q2x_reg <= c_mx[FB+QB-1:FB];
        d_q2y_reg <= c_my[FB+QB-1:FB];
        d_g00_reg <= gn2_pkg::gradient(c_h00_reg, c_dx0, c_dy0);
        d_g10_reg <= gn2_pkg::gradient(c_h10_reg, c_dx1, c_dy0);
        d_g01_reg <= gn2_pkg::gradient(c_h01_reg, c_dx0, c_dy1);
        d_g11_reg <= gn2_pkg::gradient(c_h11_reg, c_dx1, c_dy1);

        e_fx_reg  <= d_fx_reg;
        e_fy_reg  <= d_fy_reg;
        e_q3x_reg <= d_mx[FB+QB-1:FB];
        e_q3y_reg <= d_my[FB+QB-1:FB];
        e_g00_reg <= d_g00_reg;
        e_g10_reg <= d_g10_reg;
        e_g01_reg <= d_g01_reg;
        e_g11_reg <= d_g11_reg;

        f_u_reg   <= e_mx[FB+QB-1:FB];
        f_v_reg   <= e_my[FB+QB-1:FB];
        f_g00_reg <= e_g00_reg;
        f_g10_reg <= e_g10_reg;
        f_g01_reg <= e_g01_reg;
        f_g11_reg <= e_g11_reg;

        g_v_reg     <= f_v_reg;
        g_g00_reg   <= f_g00_reg;
        g_g01_reg   <= f_g01_reg;
        g_prod0_reg <= f_prod0;
        g_prod1_reg <= f_prod1;

        h_v_reg  <= g_v_reg;
        h_l0_reg <= g_g00_reg + g_prod0_reg[FB+VB-1:FB];
        h_l1_reg <= g_g01_reg + g_prod1_reg[FB+VB-1:FB];

        i_l0_reg   <= h_l0_reg;
        i_prod_reg <= h_prod;
    end

endmodule

// ===== hw/rtl/gradient_noise_2d.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Payload
// request   in         push / full      action, entry_index, entry_value,
//                                       x_position, y_position
// result    out        pop / empty      noise_value
//
// One request is taken per cycle while full is low. An evaluation passes through
// the front register, the request queue, and a nine-stage pipeline set by the fade
// multiply chain on its way to the result queue. Loads give no result. Reset
// clears the queues and pipeline valid bits; the permutation table holds nothing
// until loaded. A stalled result side fills the sixteen-entry result queue, after
// which the request queue and then full push back.

module gradient_noise_2d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                action,
    input  logic [7:0]                          entry_index,
    input  logic [7:0]                          entry_value,
    input  logic [23:0]                         x_position,
    input  logic [23:0]                         y_position,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [18:0]                  noise_value
);

    localparam int OUT_DEPTH = 1 << gn2_pkg::OUT_DEPTH_BITS;

    logic               front_valid;
    gn2_pkg::gn2_item_t front_item;
    logic               mid_full;
    logic               mid_empty;
    gn2_pkg::gn2_item_t mid_item;
    logic               mid_pop;
    logic               back_valid;
    logic [gn2_pkg::OUT_BITS-1:0] back_noise;
    logic               out_full;
    logic [gn2_pkg::OUT_BITS-1:0] out_data;
    logic               pop_take;
    logic               eval_issue;
    logic [gn2_pkg::OUT_DEPTH_BITS:0] credit_reg;
    logic [gn2_pkg::OUT_DEPTH_BITS:0] credit_next;

    gn2_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .x_position  (x_position),
        .y_position  (y_position),
        .item_valid  (front_valid),
        .item        (front_item),
        .item_ready  (!mid_full)
    );

    gn2_fifo #(
        .WIDTH      ($bits(gn2_pkg::gn2_item_t)),
        .DEPTH_BITS (gn2_pkg::MID_DEPTH_BITS)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid && !mid_full),
        .wr_data (front_item),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty),
        .full    (mid_full)
    );

    // An evaluation issues only with a reserved result queue slot.
    assign eval_issue = !mid_empty && mid_item.is_eval &&
                        (credit_reg < (gn2_pkg::OUT_DEPTH_BITS+1)'(OUT_DEPTH));
    assign mid_pop    = eval_issue || (!mid_empty && !mid_item.is_eval);
    assign pop_take   = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg;
        if (eval_issue && !pop_take)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop_take && !eval_issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    gn2_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_pop),
        .in_item   (mid_item),
        .out_valid (back_valid),
        .out_noise (back_noise)
    );

    gn2_fifo #(
        .WIDTH      (gn2_pkg::OUT_BITS),
        .DEPTH_BITS (gn2_pkg::OUT_DEPTH_BITS)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_valid),
        .wr_data (back_noise),
        .rd_en   (pop_take),
        .rd_data (out_data),
        .empty   (empty),
        .full    (out_full)
    );

    assign noise_value = $signed(out_data);

    // Reserved slots never exceed the result queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (gn2_pkg::OUT_DEPTH_BITS+1)'(OUT_DEPTH))
    else $error("result credit overrun");

    // The pipeline never delivers into a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(back_valid && out_full))
    else $error("result queue overflow");

    // A held request never enters a full request queue unnoticed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && mid_full) |-> full)
    else $error("request queue backpressure lost");

    // A full result queue means all credits are out.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_full |-> (credit_reg == (gn2_pkg::OUT_DEPTH_BITS+1)'(OUT_DEPTH)))
    else $error("credit and result queue disagree");

endmodule

// ===== sim/tb_gradient_noise_2d.sv =====
`timescale 1ns / 1ps

// Keeps the permutation table and the queue of expected noise samples.
class noise_scoreboard;
    logic [7:0]         perm [256];
    logic signed [18:0] pending_noise [$];
    int                 errors;

    function new();
        errors = 0;
        foreach (perm[i])
        begin
            perm[i] = '0;
        end
    endfunction

    // Floor division by 2^16 of a signed product.
    function longint floor_frac(longint v);
        return v >>> 16;
    endfunction

    // Quintic fade in truncating fixed point.
    function longint fade_weight(longint t);
        longint q;
        longint s;
        s = 65536;
        q = (6 * t * t + 10 * s * s - 15 * t * s) >>> 16;
        q = (q * t) >>> 16;
        q = (q * t) >>> 16;
        q = (q * t) >>> 16;
        return q;
    endfunction

    // Dot product of one corner offset with its hashed diagonal gradient.
    function longint corner_grad(int i, int j, longint dx, longint dy);
        logic [7:0] h;
        longint a;
        longint b;
        h = perm[(i + perm[j % 256]) % 256];
        a = h[0] ? dx : -dx;
        b = h[1] ? dy : -dy;
        return a + b;
    endfunction

    function longint lerp(longint a, longint b, longint w);
        return a + floor_frac((b - a) * w);
    endfunction

    // Notes an accepted request; an evaluation adds one expected sample.
    function void note_request(logic act, logic [7:0] idx, logic [7:0] val,
                               logic [23:0] xp, logic [23:0] yp);
        int cx;
        int cy;
        longint fx;
        longint fy;
        longint u;
        longint v;
        longint n;
        if (act == gn2_pkg::ACTION_LOAD)
        begin
            perm[idx] = val;
            return;
        end
        cx = int'(xp[23:16]);
        cy = int'(yp[23:16]);
        fx = longint'(xp[15:0]);
        fy = longint'(yp[15:0]);
        u = fade_weight(fx);
        v = fade_weight(fy);
        n = lerp(lerp(corner_grad(cx, cy, fx, fy),
                      corner_grad((cx + 1) % 256, cy, fx - 65536, fy), u),
                 lerp(corner_grad(cx, (cy + 1) % 256, fx, fy - 65536),
                      corner_grad((cx + 1) % 256, (cy + 1) % 256,
                                  fx - 65536, fy - 65536), u), v);
        pending_noise.push_back(n[18:0]);
    endfunction

    // Compares one popped sample with the oldest expectation.
    function void check_noise(logic signed [18:0] got);
        logic signed [18:0] want;
        if (pending_noise.size() == 0)
        begin
            $display("%0t: unexpected noise_value %0d", $time, got);
            errors++;
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want)
        begin
            $display("%0t: noise_value expected %0d actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_gradient_noise_2d;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               action;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;
    logic [23:0]        x_position;
    logic [23:0]        y_position;
    logic               empty;
    logic               pop;
    logic signed [18:0] noise_value;

    noise_scoreboard sb;
    bit              steady;

    gradient_noise_2d DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .action(action),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .x_position(x_position),
        .y_position(y_position),
        .empty(empty),
        .pop(pop),
        .noise_value(noise_value)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sends one request and holds it until accepted, with a random gap first.
    task automatic send_request(logic act, logic [7:0] idx, logic [7:0] val,
                                logic [23:0] xp, logic [23:0] yp);
        while (!steady && $urandom_range(99) < 34)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        action <= act;
        entry_index <= idx;
        entry_value <= val;
        x_position <= xp;
        y_position <= yp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(act, idx, val, xp, yp);
        @(negedge clk);
    endtask

    task automatic send_eval(logic [23:0] xp, logic [23:0] yp);
        send_request(gn2_pkg::ACTION_EVAL, 8'($urandom), 8'($urandom), xp, yp);
    endtask

    // Result side: random pop with stalls, checks on accepted pops.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= steady || ($urandom_range(99) >= 34);
            @(posedge clk);
            if (pop && !empty)
                sb.check_noise(noise_value);
        end
    end

    // Stimulus: full table load, directed corners, then random mix.
    initial
    begin
        int k;
        sb = new();
        steady = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        action = gn2_pkg::ACTION_LOAD;
        entry_index = '0;
        entry_value = '0;
        x_position = '0;
        y_position = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every entry is written before any evaluation reads the table.
        for (k = 0; k < 256; k++)
            send_request(gn2_pkg::ACTION_LOAD, k[7:0], 8'($urandom),
                         24'($urandom), 24'($urandom));

        // Directed extremes of position and loads of value extremes.
        send_eval(24'h000000, 24'h000000);
        send_eval(24'hFFFFFF, 24'hFFFFFF);
        send_eval(24'hFFFFFF, 24'h000000);
        send_eval(24'h000000, 24'hFFFFFF);
        send_eval(24'h00FFFF, 24'hFF0001);
        send_eval(24'h7F8000, 24'h808000);
        send_eval(24'hFF0000, 24'h00FFFF);
        send_request(gn2_pkg::ACTION_LOAD, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(gn2_pkg::ACTION_LOAD, 8'h00, 8'h00, 24'h000000, 24'h000000);
        send_eval(24'hFF8000, 24'hFF8000);

        // Random mix, with a stretch without idling in the middle.
        for (k = 0; k < 784; k++)
        begin
            steady = (k >= 400 && k < 550);
            if ($urandom_range(99) < 15)
                send_request(gn2_pkg::ACTION_LOAD, 8'($urandom), 8'($urandom),
                             24'($urandom), 24'($urandom));
            else
                send_eval(24'($urandom), 24'($urandom));
        end
        steady = 1'b0;
        push <= 1'b0;

        while (sb.pending_noise.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_gradient_noise_2d passed");
        else
            $display("tb_gradient_noise_2d failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("tb_gradient_noise_2d failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/gn2_pkg.sv
hw/rtl/gn2_fifo.sv
hw/rtl/gn2_front.sv
hw/rtl/gn2_back.sv
hw/rtl/gradient_noise_2d.sv
sim/tb_gradient_noise_2d.sv
